@@ sv/cjt_pkg.sv @@
// Shared types and constants for the cubic joint trajectory interpolator.
`default_nettype none

package cjt_pkg;

  // Field widths of the words and the configuration registers.
  localparam int TIME_BITS  = 48;
  localparam int DUR_BITS   = 32;
  localparam int POS_BITS   = 32;
  localparam int JOINT_BITS = 5;
  localparam int CFG_BITS   = 48;

  // Fixed-point formats: the move fraction is unsigned Q1.24 and may reach 1.0.
  localparam int FRAC_BITS = 24;
  localparam int Q_BITS    = FRAC_BITS + 1;
  localparam int T_BITS    = FRAC_BITS + 2;
  localparam int MAG_BITS  = POS_BITS + 1;

  // One quotient bit per divider stage, plus two entry and four back-end stages.
  localparam int DIV_STAGES  = Q_BITS;
  localparam int CJT_LATENCY = DIV_STAGES + 6;

  // Configuration register indexes.
  localparam logic CFG_MOVE_START_TIME = 1'b0;
  localparam logic CFG_MOVE_DURATION   = 1'b1;

  // Phase of the move reported with each result.
  typedef enum logic [1:0] {
    PHASE_BEFORE = 2'd0,
    PHASE_MOVING = 2'd1,
    PHASE_DONE   = 2'd2
  } phase_t;

  // Input word.
  typedef struct packed {
    logic [TIME_BITS-1:0]       current_time;
    logic [JOINT_BITS-1:0]      joint_number;
    logic signed [POS_BITS-1:0] joint_start;
    logic signed [POS_BITS-1:0] joint_goal;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [POS_BITS-1:0] joint_position;
    logic [JOINT_BITS-1:0]      joint_number_out;
    logic [1:0]                 move_phase;
  } out_word_t;

  // Per-item side information carried alongside the arithmetic.
  typedef struct packed {
    phase_t                     phase;
    logic signed [POS_BITS-1:0] base;
    logic [MAG_BITS-1:0]        mag;
    logic                       neg;
    logic [JOINT_BITS-1:0]      joint;
  } side_t;

endpackage

`default_nettype wire

@@ sv/cjt_div.sv @@
// Pipelined restoring divider giving the move fraction elapsed * 2^24 / duration.
`default_nettype none

module cjt_div (
  input  wire logic                           clk,
  input  wire logic [cjt_pkg::DUR_BITS-1:0]   num,
  input  wire logic [cjt_pkg::DUR_BITS-1:0]   dur,
  output logic      [cjt_pkg::Q_BITS-1:0]     quo
);
  import cjt_pkg::*;

  // Partial remainder and quotient of each stage; the remainder stays below dur while num is below twice dur.
  logic [DUR_BITS-1:0] rem_r [DIV_STAGES];
  logic [Q_BITS-1:0]   quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DUR_BITS:0]   shv;
    logic [DUR_BITS+1:0] trial;
    logic                qbit;
    logic [Q_BITS-1:0]   prevq;
    logic [DUR_BITS-1:0] rem_nxt;
    logic [Q_BITS-1:0]   quo_nxt;

    // The first stage takes the numerator as is, later ones double the remainder.
    if (k == 0) begin : g_first
      assign shv   = {1'b0, num};
      assign prevq = '0;
    end else begin : g_next
      assign shv   = {rem_r[k-1], 1'b0};
      assign prevq = quo_r[k-1];
    end

    // Trial subtraction decides one quotient bit.
    always_comb begin
      trial   = {1'b0, shv} - {2'b00, dur};
      qbit    = ~trial[DUR_BITS+1];
      rem_nxt = qbit ? trial[DUR_BITS-1:0] : shv[DUR_BITS-1:0];
      quo_nxt = {prevq[Q_BITS-2:0], qbit};
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      quo_r[k] <= quo_nxt;
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ sv/cubic_joint_trajectory.sv @@
// Top level of the cubic rest-to-rest joint trajectory interpolator.
// One word enters per clock and its result leaves as a one-cycle out_valid strobe; the
// pipeline never stalls, and busy is high only while rst_n is low.
// The latency is set by the 25-stage divider that forms the move fraction, one quotient
// bit per stage, plus two entry stages and four multiply and output stages.
`default_nettype none

module cubic_joint_trajectory (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cjt_pkg::in_word_t               in_data,
  output logic                                 out_valid,
  output cjt_pkg::out_word_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [cjt_pkg::CFG_BITS-1:0]    cfg_data
);
  import cjt_pkg::*;

  // Configuration registers.
  logic [TIME_BITS-1:0] start_time_r;
  logic [DUR_BITS-1:0]  dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= '0;
      dur_r        <= DUR_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MOVE_START_TIME: start_time_r <= cfg_data[TIME_BITS-1:0];
        CFG_MOVE_DURATION:   dur_r        <= cfg_data[DUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = ~rst_n;

  logic accept;
  assign accept = start & ~busy;

  // Stage 1: elapsed time and the before-start flag from one wide subtraction.
  logic                       s1_vld_r;
  logic [TIME_BITS-1:0]       s1_elapsed_r;
  logic                       s1_before_r;
  logic [JOINT_BITS-1:0]      s1_joint_r;
  logic signed [POS_BITS-1:0] s1_start_r;
  logic signed [POS_BITS-1:0] s1_goal_r;
  logic [TIME_BITS:0]         el_full;

  assign el_full = {1'b0, in_data.current_time} - {1'b0, start_time_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_elapsed_r <= el_full[TIME_BITS-1:0];
    s1_before_r  <= el_full[TIME_BITS];
    s1_joint_r   <= in_data.joint_number;
    s1_start_r   <= in_data.joint_start;
    s1_goal_r    <= in_data.joint_goal;
  end

  // Stage 2: phase, the position the result falls back on, and the move magnitude.
  logic                s2_vld_r;
  logic [DUR_BITS-1:0] s2_num_r;
  side_t               s2_side_r;
  side_t               s2_side_nxt;
  logic                over;
  logic [MAG_BITS-1:0] diff_up;
  logic [MAG_BITS-1:0] diff_dn;

  always_comb begin
    over    = (s1_elapsed_r > {{(TIME_BITS-DUR_BITS){1'b0}}, dur_r}) || (dur_r == '0);
    diff_up = {s1_goal_r[POS_BITS-1], s1_goal_r} - {s1_start_r[POS_BITS-1], s1_start_r};
    diff_dn = {s1_start_r[POS_BITS-1], s1_start_r} - {s1_goal_r[POS_BITS-1], s1_goal_r};
    s2_side_nxt.neg   = (s1_goal_r < s1_start_r);
    s2_side_nxt.mag   = s2_side_nxt.neg ? diff_dn : diff_up;
    s2_side_nxt.joint = s1_joint_r;
    if (s1_before_r) begin
      s2_side_nxt.phase = PHASE_BEFORE;
      s2_side_nxt.base  = s1_start_r;
    end else if (over) begin
      s2_side_nxt.phase = PHASE_DONE;
      s2_side_nxt.base  = s1_goal_r;
    end else begin
      s2_side_nxt.phase = PHASE_MOVING;
      s2_side_nxt.base  = s1_start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_num_r  <= s1_elapsed_r[DUR_BITS-1:0];
    s2_side_r <= s2_side_nxt;
  end

  // Divider stages with the side information delayed to match.
  logic [Q_BITS-1:0]     frac;
  logic [DIV_STAGES-1:0] vld_d_r;
  side_t                 side_d_r [DIV_STAGES];

  cjt_div u_div (
    .clk (clk),
    .num (s2_num_r),
    .dur (dur_r),
    .quo (frac)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= '0;
    end else begin
      vld_d_r <= {vld_d_r[DIV_STAGES-2:0], s2_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    side_d_r[0] <= s2_side_r;
    for (int k = 1; k < DIV_STAGES; k++) begin
      side_d_r[k] <= side_d_r[k-1];
    end
  end

  // M1: square of the fraction and the factor 3 - 2s.
  logic                  m1_vld_r;
  logic [Q_BITS-1:0]     m1_sq_r;
  logic [T_BITS-1:0]     m1_t_r;
  side_t                 m1_side_r;
  logic [2*Q_BITS-1:0]   sq_full;

  assign sq_full = (2*Q_BITS)'(frac) * (2*Q_BITS)'(frac);

  // M2: cubic blend weight.
  logic                   m2_vld_r;
  logic [Q_BITS-1:0]      m2_blend_r;
  side_t                  m2_side_r;
  logic [Q_BITS+T_BITS-1:0] blend_full;

  assign blend_full = (Q_BITS+T_BITS)'(m1_sq_r) * (Q_BITS+T_BITS)'(m1_t_r);

  // M3: weighted magnitude of the move, truncated toward zero.
  logic                       m3_vld_r;
  logic [MAG_BITS-1:0]        m3_scaled_r;
  side_t                      m3_side_r;
  logic [MAG_BITS+Q_BITS-1:0] prod_full;

  assign prod_full = (MAG_BITS+Q_BITS)'(m2_side_r.mag) * (MAG_BITS+Q_BITS)'(m2_blend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= vld_d_r[DIV_STAGES-1];
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_sq_r     <= sq_full[FRAC_BITS+Q_BITS-1:FRAC_BITS];
    m1_t_r      <= T_BITS'(3 * (1 << FRAC_BITS)) - {frac, 1'b0};
    m1_side_r   <= side_d_r[DIV_STAGES-1];
    m2_blend_r  <= blend_full[FRAC_BITS+Q_BITS-1:FRAC_BITS];
    m2_side_r   <= m1_side_r;
    m3_scaled_r <= prod_full[FRAC_BITS+MAG_BITS-1:FRAC_BITS];
    m3_side_r   <= m2_side_r;
  end

  // Output register: apply the signed offset to the start position while moving.
  logic                  out_valid_r;
  out_word_t             out_data_r;
  out_word_t             out_data_nxt;
  logic [POS_BITS+1:0]   base_ext;
  logic [POS_BITS+1:0]   pos_sum;

  always_comb begin
    base_ext = {{2{m3_side_r.base[POS_BITS-1]}}, m3_side_r.base};
    pos_sum  = m3_side_r.neg ? base_ext - {1'b0, m3_scaled_r}
                             : base_ext + {1'b0, m3_scaled_r};
    out_data_nxt.joint_number_out = m3_side_r.joint;
    out_data_nxt.move_phase       = m3_side_r.phase;
    if (m3_side_r.phase == PHASE_MOVING) begin
      out_data_nxt.joint_position = pos_sum[POS_BITS-1:0];
    end else begin
      out_data_nxt.joint_position = m3_side_r.base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ sv/cjt_chk.sv @@
// Port-level checker for the cubic joint trajectory interpolator and its bind.
`default_nettype none

module cjt_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire cjt_pkg::in_word_t             in_data,
  input wire logic                          out_valid,
  input wire cjt_pkg::out_word_t            out_data
);
  import cjt_pkg::*;

  // Every accepted word yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##CJT_LATENCY out_valid)
    else $error("accepted word produced no result");

  // No result appears without a word accepted one latency earlier.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, CJT_LATENCY))
    else $error("result without matching word");

  // The joint index travels through unchanged.
  a_joint_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.joint_number_out == $past(in_data.joint_number, CJT_LATENCY))
    else $error("joint index corrupted");

  // Before the move starts the start position is reported.
  a_before_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.move_phase == PHASE_BEFORE) |->
      out_data.joint_position == $past(in_data.joint_start, CJT_LATENCY))
    else $error("position before start differs from start");

endmodule

bind cubic_joint_trajectory cjt_chk u_cjt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
